[rtl/core/prime_count_accumulator_core_defines.svh]
// assertion macros for the prime count accumulator
`ifndef PRIME_COUNT_ACCUMULATOR_CORE_DEFINES_SVH
`define PRIME_COUNT_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCA_ASSERT_NOW(label, ante, cons, msg)
`define PCA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/pca_pkg.sv]
// shared constants and controller/datapath interface types
`default_nettype none
package pca_pkg;
  localparam int VALUE_WIDTH = 16;
  localparam int BIT_W       = $clog2(VALUE_WIDTH);
  localparam int COUNT_W     = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic load;      // capture input item
    logic init_d;    // first divisor
    logic div_init;  // start a remainder computation
    logic div_step;  // one restoring step
    logic next_d;    // advance divisor and its square
    logic count;     // update running count
    logic emit;      // move count to output register and clear
    logic prime;     // verdict for count update
  } pca_cmd_t;

  typedef struct packed {
    logic trivial;   // negative, zero or one
    logic sq_gt;     // divisor squared exceeds value
    logic div_last;  // current step is the final bit
    logic rem_zero;  // remainder is zero
    logic last;      // captured last flag
  } pca_sts_t;
endpackage
`default_nettype wire

[rtl/core/prime_count_accumulator_core.sv]
// top level: prime count accumulator with trial division primality test
`default_nettype none
// Each item carries a signed value and a last flag. The value is tested for
// primality by trial division with divisors 2, 3, ... while the divisor
// squared does not exceed the value, stopping at the first divisor that
// leaves no remainder; negative values, zero and one are not prime. Primes
// bump a 16-bit running count that saturates at its maximum. On an item
// with last set the count, including that item, is sent as one result item
// and cleared. One item is worked on at a time: an item that is negative or
// below two goes straight from the check to the finish step; otherwise each
// trial runs one restoring step per value bit in the shared bit-serial
// remainder unit (one quotient bit per cycle) and then checks the remainder,
// with at most about sqrt(value) - 1 trials per item. The result sits in an
// output register, so new items are accepted while it waits; only a last
// item that finds the previous result still unclaimed waits for it.
`include "prime_count_accumulator_core_defines.svh"
module prime_count_accumulator_core (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          in_valid,
  output logic                                         in_stall,
  input  wire logic signed [pca_pkg::VALUE_WIDTH-1:0]  in_value,
  input  wire                                          in_last,
  output logic                                         out_valid,
  input  wire                                          out_stall,
  output logic [pca_pkg::COUNT_W-1:0]                  out_prime_count
);
  import pca_pkg::*;

  // command and status between sequencer and datapath
  pca_cmd_t cmd;
  pca_sts_t sts;

  // sequencer: owns state, verdict and output valid
  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: operands, remainder unit, count and output data
  pca_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_value        (in_value),
    .in_last         (in_last),
    .sts             (sts),
    .out_prime_count (out_prime_count)
  );

  // an accepted item keeps the input side busy in the cycle after acceptance
  `PCA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  // a new result only appears as the sequencer returns to idle
  `PCA_ASSERT_NOW(a_emit_at_finish, $rose(out_valid), !in_stall && $past(in_stall), "stray result")
  // emit is only issued together with a count update
  `PCA_ASSERT_NOW(a_emit_counts, cmd.emit, cmd.count && sts.last, "emit without count")
endmodule
`default_nettype wire

[rtl/core/pca_dp.sv]
// datapath: value, divisor, square, remainder unit, running count, output data
`default_nettype none
module pca_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  pca_pkg::pca_cmd_t                     cmd,
  input  wire logic signed [pca_pkg::VALUE_WIDTH-1:0] in_value,
  input  wire                                   in_last,
  output pca_pkg::pca_sts_t                     sts,
  output logic [pca_pkg::COUNT_W-1:0]           out_prime_count
);
  import pca_pkg::*;

  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0]      v_r;
  logic               last_r;
  logic [VW-1:0]      d_r;
  logic [2*VW-1:0]    sq_r;
  logic [VW-1:0]      rem_r;
  logic [BIT_W-1:0]   bit_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] out_r;

  logic [VW:0]        rem_sh;
  logic [VW:0]        rem_sub;
  logic [VW-1:0]      rem_nxt;
  logic [COUNT_W-1:0] cnt_inc;

  // restoring step: shift in the next value bit, subtract divisor if it fits
  assign rem_sh  = {rem_r, v_r[bit_r]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign rem_nxt = (rem_sh >= {1'b0, d_r}) ? rem_sub[VW-1:0] : rem_sh[VW-1:0];

  assign cnt_inc = (cmd.prime && (cnt_r != COUNT_MAX)) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= unsigned'(in_value);
      last_r <= in_last;
    end
    if (cmd.init_d) begin
      d_r  <= VW'(2);
      sq_r <= (2*VW)'(4);
    end else if (cmd.next_d) begin
      d_r  <= d_r + 1'b1;
      sq_r <= sq_r + {{VW-1{1'b0}}, d_r, 1'b0} + 1'b1;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      bit_r <= BIT_W'(VW-1);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      bit_r <= bit_r - 1'b1;
    end
    if (cmd.emit) begin
      out_r <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.count) begin
      cnt_r <= cmd.emit ? '0 : cnt_inc;
    end
  end

  assign sts.trivial  = v_r[VW-1] || (v_r < VW'(2));
  assign sts.sq_gt    = sq_r > {{VW{1'b0}}, v_r};
  assign sts.div_last = (bit_r == '0);
  assign sts.rem_zero = (rem_r == '0);
  assign sts.last     = last_r;

  assign out_prime_count = out_r;
endmodule
`default_nettype wire

[rtl/core/pca_ctrl.sv]
// controller: trial division sequencer and output handshake
`default_nettype none
module pca_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire                out_stall,
  input  pca_pkg::pca_sts_t  sts,
  output pca_pkg::pca_cmd_t  cmd
);
  import pca_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TRIAL,
    ST_DIV,
    ST_REM,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   prime_r, prime_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    prime_nxt     = prime_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.prime     = prime_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.trivial) begin
          prime_nxt = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.init_d = 1'b1;
          state_nxt  = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        if (sts.sq_gt) begin
          prime_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        if (sts.rem_zero) begin
          prime_nxt = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.next_d = 1'b1;
          state_nxt  = ST_TRIAL;
        end
      end
      ST_FINISH: begin
        if (!sts.last) begin
          cmd.count = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.count     = 1'b1;
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prime_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prime_r     <= prime_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire
